// File: rtl/tlex_pkg.sv
`default_nettype none
package tlex_pkg;

  localparam int MAX_TOKEN_LEN = 255;
  localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int WIN_DEPTH     = 6;
  localparam int NUM_KW        = 13;
  localparam int LEN_CAP       = 255;
  localparam int LEN_OVF_SHOWN = (MAX_TOKEN_LEN > LEN_CAP) ? LEN_CAP : MAX_TOKEN_LEN;

  // token kinds
  localparam logic [5:0] K_IDENT  = 6'd0;
  localparam logic [5:0] K_INT    = 6'd1;
  localparam logic [5:0] K_CHAR   = 6'd2;
  localparam logic [5:0] K_STR    = 6'd3;
  localparam logic [5:0] K_KW0    = 6'd4;
  localparam logic [5:0] K_KW_END = 6'd16;
  localparam logic [5:0] K_PLUS   = 6'd17;
  localparam logic [5:0] K_MINUS  = 6'd18;
  localparam logic [5:0] K_STAR   = 6'd19;
  localparam logic [5:0] K_SLASH  = 6'd20;
  localparam logic [5:0] K_LSS    = 6'd21;
  localparam logic [5:0] K_LEQ    = 6'd22;
  localparam logic [5:0] K_GRE    = 6'd23;
  localparam logic [5:0] K_GEQ    = 6'd24;
  localparam logic [5:0] K_EQL    = 6'd25;
  localparam logic [5:0] K_NEQ    = 6'd26;
  localparam logic [5:0] K_ASSIGN = 6'd27;
  localparam logic [5:0] K_SEMI   = 6'd28;
  localparam logic [5:0] K_COMMA  = 6'd29;
  localparam logic [5:0] K_LPAREN = 6'd30;
  localparam logic [5:0] K_RPAREN = 6'd31;
  localparam logic [5:0] K_LBRACK = 6'd32;
  localparam logic [5:0] K_RBRACK = 6'd33;
  localparam logic [5:0] K_LBRACE = 6'd34;
  localparam logic [5:0] K_RBRACE = 6'd35;
  localparam logic [5:0] K_ERR    = 6'd36;

  typedef enum logic [9:0] {
    M_IDLE  = 10'b00_0000_0001,
    M_IDENT = 10'b00_0000_0010,
    M_INT   = 10'b00_0000_0100,
    M_CHAR1 = 10'b00_0000_1000,
    M_CHAR2 = 10'b00_0001_0000,
    M_STR   = 10'b00_0010_0000,
    M_LT    = 10'b00_0100_0000,
    M_GT    = 10'b00_1000_0000,
    M_EQ    = 10'b01_0000_0000,
    M_BANG  = 10'b10_0000_0000
  } mode_t;

  typedef logic [0:WIN_DEPTH-1][7:0] kw_word_t;

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] len;
    logic       ovf;
    logic       last;
  } tok_t;

  typedef struct packed {
    mode_t      mode;
    logic       emit;
    logic [5:0] kind;
    logic       start;
    logic       add;
  } idle_t;

  localparam kw_word_t KW_TEXT [NUM_KW] = '{
    {"const", 8'h00}, {"int", 24'h0}, {"char", 16'h0}, {"void", 16'h0},
    {"main", 16'h0}, {"if", 32'h0}, {"else", 16'h0}, {"do", 32'h0},
    {"while", 8'h00}, {"for", 24'h0}, {"scanf", 8'h00}, {"printf"}, {"return"}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd5, 3'd3, 3'd4, 3'd4, 3'd4, 3'd2, 3'd4, 3'd2, 3'd5, 3'd3, 3'd5, 3'd6, 3'd6
  };

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] b);
    logic [5:0] k;
    unique case (b)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      ";":     k = K_SEMI;
      ",":     k = K_COMMA;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      default: k = K_ERR;
    endcase
    return k;
  endfunction

  // Match a window of len bytes against the keyword list.
  function automatic logic [5:0] kw_lookup(input kw_word_t w, input logic [2:0] len);
    logic [5:0] k;
    logic       found;
    logic       hit;
    k     = K_IDENT;
    found = 1'b0;
    for (int i = 0; i < NUM_KW; i++) begin
      hit = (KW_LEN[i] == len);
      for (int j = 0; j < WIN_DEPTH; j++) begin
        if (3'(j) < KW_LEN[i] && w[j] != KW_TEXT[i][j]) begin
          hit = 1'b0;
        end
      end
      if (hit && !found) begin
        found = 1'b1;
        k     = K_KW0 + 6'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [7:0] sat_len(input logic [CNT_W-1:0] c);
    logic [7:0] r;
    if (32'(c) > LEN_CAP) begin
      r = 8'(LEN_CAP);
    end else begin
      r = 8'(c);
    end
    return r;
  endfunction

  // Decide what a byte does when scanned from the idle state.
  function automatic idle_t idle_scan(input logic [7:0] b);
    idle_t s;
    s = '{mode: M_IDLE, emit: 1'b0, kind: K_ERR, start: 1'b0, add: 1'b0};
    if (is_space(b)) begin
      s.mode = M_IDLE;
    end else if (is_alpha(b) || b == "_") begin
      s.mode  = M_IDENT;
      s.start = 1'b1;
      s.add   = 1'b1;
    end else if (is_digit(b)) begin
      s.mode  = M_INT;
      s.start = 1'b1;
      s.add   = 1'b1;
    end else if (b == "'") begin
      s.mode  = M_CHAR1;
      s.start = 1'b1;
    end else if (b == "\"") begin
      s.mode  = M_STR;
      s.start = 1'b1;
    end else if (b == "<") begin
      s.mode = M_LT;
    end else if (b == ">") begin
      s.mode = M_GT;
    end else if (b == "=") begin
      s.mode = M_EQ;
    end else if (b == "!") begin
      s.mode = M_BANG;
    end else begin
      s.emit = 1'b1;
      s.kind = single_op(b);
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/tlex_if.sv
`default_nettype none
interface tlex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tlex_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] token_kind;
  logic [7:0] token_length;
  logic       length_overflow;
  logic       last_of_run;

  modport source (output valid, output token_kind, output token_length,
                  output length_overflow, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_length,
                  input length_overflow, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/token_lexer_c_subset_unit.sv
`default_nettype none
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    text_byte[7:0], end_of_text
// out_chan  out  valid/ready    token_kind[5:0], token_length[7:0],
//                               length_overflow, last_of_run
//
// One byte per cycle while the queue has room; a byte reaches out_chan via
// the input register, then the four-entry result queue. A byte that
// completes two tokens puts both in the queue at once; they leave one per
// cycle unless out_chan stalls; in_chan.ready drops while a held byte finds
// fewer than two free slots. Synchronous reset (rst_n low) idles the scanner
// and empties the queue; no clearing pass. Stalls hold the head token steady.
module token_lexer_c_subset_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tlex_in_if.sink     in_chan,
  tlex_out_if.source  out_chan
);

  localparam int QD   = 4;
  localparam int QC_W = $clog2(QD + 1);

  // input register
  logic       s_vld_r;
  logic [7:0] s_byte_r;
  logic       s_eot_r;
  logic       fire;
  logic       load;

  // scanner state
  tlex_pkg::mode_t          mode_r, mode_nxt;
  logic [tlex_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;
  tlex_pkg::kw_word_t       win_r, win_nxt;

  // result queue; entry 0 is the head
  tlex_pkg::tok_t  q_r [QD];
  tlex_pkg::tok_t  q_nxt [QD];
  logic [QC_W-1:0] q_cnt_r, q_cnt_nxt;
  logic [QC_W-1:0] qc_after;
  logic            pop;

  // tokens produced by the byte in the input register
  tlex_pkg::tok_t tok_a, tok_b, r0, r1;
  logic           a_v, b_v;
  logic [1:0]     n_tok;
  logic           rescan;
  logic           start, add;
  tlex_pkg::idle_t is_s;
  logic [tlex_pkg::CNT_W-1:0] base_cnt;
  logic           base_ovf;
  logic [5:0]     word_kind;
  logic [7:0]     cur_len;

  // Handshakes: advance the input register only when the queue can take two.
  assign pop      = out_chan.valid && out_chan.ready;
  assign qc_after = q_cnt_r - QC_W'(pop);
  assign fire     = s_vld_r && (qc_after <= QC_W'(QD - 2));
  assign in_chan.ready = !s_vld_r || fire;
  assign load     = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (load) begin
      s_vld_r <= 1'b1;
    end else if (fire) begin
      s_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s_byte_r <= in_chan.text_byte;
      s_eot_r  <= in_chan.end_of_text;
    end
  end

  // Identifier kind: only short lexemes can be keywords.
  always_comb begin
    if (ovf_r || cnt_r > tlex_pkg::CNT_W'(tlex_pkg::WIN_DEPTH)) begin
      word_kind = tlex_pkg::K_IDENT;
    end else begin
      word_kind = tlex_pkg::kw_lookup(win_r, cnt_r[2:0]);
    end
  end

  assign cur_len = tlex_pkg::sat_len(cnt_r);
  assign is_s    = tlex_pkg::idle_scan(s_byte_r);

  // Scan one byte: tok_a is the token closed by the byte, tok_b the token the
  // byte itself forms when it is scanned again from idle.
  always_comb begin
    mode_nxt = mode_r;
    a_v      = 1'b0;
    tok_a    = '{kind: tlex_pkg::K_ERR, len: 8'd1, ovf: 1'b0, last: 1'b0};
    rescan   = 1'b0;
    start    = 1'b0;
    add      = 1'b0;

    if (s_eot_r) begin
      // flush the pending token and end the text
      mode_nxt = tlex_pkg::M_IDLE;
      unique case (mode_r)
        tlex_pkg::M_IDENT: begin
          a_v   = 1'b1;
          tok_a = '{kind: word_kind, len: cur_len, ovf: ovf_r, last: 1'b0};
        end
        tlex_pkg::M_INT: begin
          a_v   = 1'b1;
          tok_a = '{kind: tlex_pkg::K_INT, len: cur_len, ovf: ovf_r, last: 1'b0};
        end
        tlex_pkg::M_CHAR1, tlex_pkg::M_CHAR2, tlex_pkg::M_STR: begin
          a_v   = 1'b1;
          tok_a = '{kind: tlex_pkg::K_ERR, len: cur_len, ovf: ovf_r, last: 1'b0};
        end
        tlex_pkg::M_LT: begin
          a_v        = 1'b1;
          tok_a.kind = tlex_pkg::K_LSS;
        end
        tlex_pkg::M_GT: begin
          a_v        = 1'b1;
          tok_a.kind = tlex_pkg::K_GRE;
        end
        tlex_pkg::M_EQ: begin
          a_v        = 1'b1;
          tok_a.kind = tlex_pkg::K_ASSIGN;
        end
        tlex_pkg::M_BANG: begin
          a_v = 1'b1;
        end
        default: begin
          a_v = 1'b0;
        end
      endcase
    end else begin
      unique case (mode_r)
        tlex_pkg::M_IDENT: begin
          if (tlex_pkg::is_word(s_byte_r)) begin
            add = 1'b1;
          end else begin
            a_v    = 1'b1;
            tok_a  = '{kind: word_kind, len: cur_len, ovf: ovf_r, last: 1'b0};
            rescan = 1'b1;
          end
        end
        tlex_pkg::M_INT: begin
          if (tlex_pkg::is_digit(s_byte_r)) begin
            add = 1'b1;
          end else begin
            a_v    = 1'b1;
            tok_a  = '{kind: tlex_pkg::K_INT, len: cur_len, ovf: ovf_r, last: 1'b0};
            rescan = 1'b1;
          end
        end
        tlex_pkg::M_CHAR1: begin
          // any byte, a quote too, is the content byte
          add      = 1'b1;
          mode_nxt = tlex_pkg::M_CHAR2;
        end
        tlex_pkg::M_CHAR2: begin
          a_v = 1'b1;
          if (s_byte_r == "'") begin
            tok_a.kind = tlex_pkg::K_CHAR;
            mode_nxt   = tlex_pkg::M_IDLE;
          end else begin
            rescan = 1'b1;
          end
        end
        tlex_pkg::M_STR: begin
          if (s_byte_r == "\"") begin
            a_v      = 1'b1;
            tok_a    = '{kind: tlex_pkg::K_STR, len: cur_len, ovf: ovf_r, last: 1'b0};
            mode_nxt = tlex_pkg::M_IDLE;
          end else begin
            add = 1'b1;
          end
        end
        tlex_pkg::M_LT, tlex_pkg::M_GT, tlex_pkg::M_EQ, tlex_pkg::M_BANG: begin
          a_v = 1'b1;
          if (s_byte_r == "=") begin
            tok_a.len = 8'd2;
            mode_nxt  = tlex_pkg::M_IDLE;
            priority case (1'b1)
              mode_r == tlex_pkg::M_LT: tok_a.kind = tlex_pkg::K_LEQ;
              mode_r == tlex_pkg::M_GT: tok_a.kind = tlex_pkg::K_GEQ;
              mode_r == tlex_pkg::M_EQ: tok_a.kind = tlex_pkg::K_EQL;
              default:                  tok_a.kind = tlex_pkg::K_NEQ;
            endcase
          end else begin
            rescan = 1'b1;
            // a lone bang keeps the error kind
            priority case (1'b1)
              mode_r == tlex_pkg::M_LT: tok_a.kind = tlex_pkg::K_LSS;
              mode_r == tlex_pkg::M_GT: tok_a.kind = tlex_pkg::K_GRE;
              mode_r == tlex_pkg::M_EQ: tok_a.kind = tlex_pkg::K_ASSIGN;
              default:                  tok_a.kind = tlex_pkg::K_ERR;
            endcase
          end
        end
        default: begin
          rescan = 1'b1;
        end
      endcase
    end

    // scan the byte again from idle
    b_v   = rescan && is_s.emit;
    tok_b = '{kind: is_s.kind, len: 8'd1, ovf: 1'b0, last: 1'b1};
    if (rescan) begin
      mode_nxt = is_s.mode;
      start    = is_s.start;
      add      = is_s.add;
    end
  end

  // Lexeme bookkeeping: restart, then append the byte with saturation.
  always_comb begin
    base_cnt = start ? '0 : cnt_r;
    base_ovf = start ? 1'b0 : ovf_r;
    cnt_nxt  = base_cnt;
    ovf_nxt  = base_ovf;
    win_nxt  = win_r;
    if (add) begin
      if (base_cnt < tlex_pkg::CNT_W'(tlex_pkg::WIN_DEPTH)) begin
        win_nxt[base_cnt[2:0]] = s_byte_r;
      end
      if (base_cnt < tlex_pkg::CNT_W'(tlex_pkg::MAX_TOKEN_LEN)) begin
        cnt_nxt = base_cnt + tlex_pkg::CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tlex_pkg::M_IDLE;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // keyword window holds no reset: only written bytes are ever compared
  always_ff @(posedge clk) begin
    if (fire) begin
      win_r <= win_nxt;
    end
  end

  // Pack the produced tokens and mark the final one of the transaction.
  always_comb begin
    n_tok = 2'(a_v) + 2'(b_v);
    r0    = a_v ? tok_a : tok_b;
    r0.last = !(a_v && b_v);
    r1    = tok_b;
  end

  // Queue: drop the head on pop, then append at the new tail.
  always_comb begin
    for (int i = 0; i < QD; i++) begin
      if (pop && i < QD - 1) begin
        q_nxt[i] = q_r[(i + 1) % QD];
      end else begin
        q_nxt[i] = q_r[i];
      end
    end
    q_cnt_nxt = qc_after;
    if (fire) begin
      for (int i = 0; i < QD; i++) begin
        if (n_tok != 2'd0 && QC_W'(i) == qc_after) begin
          q_nxt[i] = r0;
        end
        if (n_tok == 2'd2 && QC_W'(i) == qc_after + QC_W'(1)) begin
          q_nxt[i] = r1;
        end
      end
      q_cnt_nxt = qc_after + QC_W'(n_tok);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_chan.valid           = (q_cnt_r != '0);
  assign out_chan.token_kind      = q_r[0].kind;
  assign out_chan.token_length    = q_r[0].len;
  assign out_chan.length_overflow = q_r[0].ovf;
  assign out_chan.last_of_run     = q_r[0].last;

endmodule
`default_nettype wire

// File: rtl/tlex_checker.sv
`default_nettype none
module tlex_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] token_kind,
  input wire logic [7:0] token_length,
  input wire logic       length_overflow,
  input wire logic       last_of_run
);

  // no token right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(token_kind)
      && $stable(token_length) && $stable(length_overflow) && $stable(last_of_run))
    else $error("stalled token changed");

  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && length_overflow |->
      token_length == 8'(tlex_pkg::LEN_OVF_SHOWN) && token_kind != tlex_pkg::K_CHAR)
    else $error("overflow flag without saturated length");

  a_op_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind >= tlex_pkg::K_PLUS && token_kind < tlex_pkg::K_ERR |->
      !length_overflow && (token_length == 8'd1 || token_length == 8'd2))
    else $error("operator token with bad length");

  a_kw_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && token_kind >= tlex_pkg::K_KW0 && token_kind <= tlex_pkg::K_KW_END |->
      !length_overflow && token_length >= 8'd2 && token_length <= 8'd6)
    else $error("keyword token with bad length");

endmodule

bind token_lexer_c_subset_unit tlex_checker u_tlex_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .token_kind      (out_chan.token_kind),
  .token_length    (out_chan.token_length),
  .length_overflow (out_chan.length_overflow),
  .last_of_run     (out_chan.last_of_run)
);
`default_nettype wire
